// File: rtl/nfjh_pkg.sv
// Shared types and constants for the notch filter with jitter histogram.
package nfjh_pkg;

   localparam int          Q_DEPTH      = 4;
   localparam int          Q_PTR_W      = 2;
   localparam int          Q_CNT_W      = Q_PTR_W + 1;
   localparam logic [31:0] PERIOD_RESET = 32'd40000;

   typedef struct packed {
      logic [11:0] sample;
      logic [31:0] timestamp;
   } req_type;

   typedef struct packed {
      logic signed [31:0] filtered;
      logic               jitter_valid;
      logic [29:0]        jitter;
      logic [29:0]        max_jitter;
      logic [31:0]        bin_count;
   } rsp_type;

   // One classified item on its way from the front part to the back part.
   typedef struct packed {
      logic [31:0] xpart;
      logic        jit_valid;
      logic [29:0] jit;
   } qent_type;

endpackage

// File: rtl/notch_filter_with_jitter_histogram.sv
// Notch filter with timing jitter histogram: top level.
// Path: an accepted item passes the front step, the queue and the back step before its result is offered.
// Throughput: one item per cycle while no stall holds the flow; the back step closes the filter recursion and
// the bin read-modify-write, with forwarding between neighboring items.
// Reset: synchronous; afterwards the histogram memory is swept to zero, one bin per cycle,
// through all HIST_BINS bins, with req_stall high. Configuration writes are taken at any time.
module notch_filter_with_jitter_histogram #(
   parameter int HIST_BINS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  nfjh_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nfjh_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_data
);
   import nfjh_pkg::*;

   logic               clearing;
   logic [Q_CNT_W-1:0] q_count;
   logic               q_push, q_pop, q_valid;
   qent_type           q_push_data, q_head;

   nfjh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .clearing    (clearing),
      .q_count     (q_count),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   nfjh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head),
      .count      (q_count)
   );

   nfjh_back #(
      .HIST_BINS (HIST_BINS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/nfjh_front.sv
// Front part: takes items, keeps input history, forms the feed-forward term and the jitter.
module nfjh_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  nfjh_pkg::req_type             req_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [31:0]                   csr_data,
   input  logic                          clearing,
   input  logic [nfjh_pkg::Q_CNT_W-1:0]  q_count,
   output logic                          q_push,
   output nfjh_pkg::qent_type            q_push_data
);
   import nfjh_pkg::*;

   logic [31:0] period_ff;
   logic [11:0] x1_ff, x2_ff;
   logic [31:0] prev_ff;
   logic        seen_ff;

   logic        a_valid_ff;
   logic        a_first_ff;
   logic [31:0] a_xpart_ff, a_xpart_in;
   logic [31:0] a_diff_ff, a_diff_in;

   logic              accept;
   logic [Q_CNT_W-1:0] fill;
   logic [12:0]       xsum;
   logic [31:0]       err;
   logic [32:0]       jsum;

   assign csr_ready = 1'b1;

   // An item in the first step always lands in the queue at the next edge, so it counts as held.
   assign fill      = q_count + {{(Q_CNT_W-1){1'b0}}, a_valid_ff};
   assign req_stall = clearing || (fill >= Q_CNT_W'(Q_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      xsum       = {1'b0, req_data.sample} + {1'b0, x2_ff};
      a_xpart_in = {11'd0, xsum, 8'd0} - ({20'd0, x1_ff} * 32'd503) + 32'd128;
      a_diff_in  = req_data.timestamp - prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         x1_ff      <= '0;
         x2_ff      <= '0;
         prev_ff    <= '0;
         seen_ff    <= 1'b0;
         a_valid_ff <= 1'b0;
         a_first_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            period_ff <= csr_data;
         end
         a_valid_ff <= accept;
         if (accept) begin
            x2_ff      <= x1_ff;
            x1_ff      <= req_data.sample;
            prev_ff    <= req_data.timestamp;
            seen_ff    <= 1'b1;
            a_first_ff <= !seen_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_xpart_ff <= a_xpart_in;
         a_diff_ff  <= a_diff_in;
      end
   end

   // The rounding add is one bit wider so that the largest error does not wrap.
   always_comb begin
      err  = (a_diff_ff > period_ff) ? (a_diff_ff - period_ff) : (period_ff - a_diff_ff);
      jsum = {1'b0, err} + 33'd4;
      q_push_data.xpart     = a_xpart_ff;
      q_push_data.jit_valid = !a_first_ff;
      q_push_data.jit       = a_first_ff ? 30'd0 : jsum[32:3];
   end

   assign q_push = a_valid_ff;

endmodule

// File: rtl/nfjh_queue.sv
// Short queue that decouples the front part from the back part.
module nfjh_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  nfjh_pkg::qent_type            push_data,
   input  logic                          pop,
   output logic                          head_valid,
   output nfjh_pkg::qent_type            head,
   output logic [nfjh_pkg::Q_CNT_W-1:0]  count
);
   import nfjh_pkg::*;

   qent_type           slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/nfjh_back.sv
// Back part: post-reset bin clear, filter recursion, histogram read-modify-write, peak tracking and output register.
module nfjh_back #(
   parameter int HIST_BINS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  nfjh_pkg::qent_type  q_head,
   output logic                q_pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output nfjh_pkg::rsp_type   rsp_data
);
   import nfjh_pkg::*;

   localparam int             BIN_W    = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HIST_BINS - 1);

   logic [31:0] bins_mem [HIST_BINS];

   logic             clear_ff;
   logic [BIN_W-1:0] clr_cnt_ff;

   logic             s2_valid_ff;
   qent_type         s2_ff;
   logic [BIN_W-1:0] s2_idx_ff;
   logic [31:0]      rd_ff;
   logic             fwd_hit_ff;
   logic [31:0]      fwd_val_ff;

   logic [31:0] y1_ff, y2_ff;
   logic [29:0] peak_ff, peak_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic             out_can, s2_done;
   logic [BIN_W-1:0] rd_idx;
   logic [31:0]      base, count, acc, acc_adj, y;
   logic             mem_we;
   logic [BIN_W-1:0] mem_wa;
   logic [31:0]      mem_wd;

   assign clearing = clear_ff;
   assign out_can  = !rsp_valid_ff || !rsp_stall;
   assign s2_done  = s2_valid_ff && out_can;
   assign q_pop    = q_valid && !clear_ff && (!s2_valid_ff || s2_done);
   assign rd_idx   = (q_head.jit >= 30'(HIST_BINS)) ? LAST_BIN : q_head.jit[BIN_W-1:0];

   // A bin written at the same edge as this item's read comes from the forward register.
   always_comb begin
      base  = fwd_hit_ff ? fwd_val_ff : rd_ff;
      count = base + 32'd1;
      acc   = s2_ff.xpart + (y1_ff * 32'd498) - (y2_ff * 32'd251);
      // Arithmetic shift after a bias on negatives gives division toward zero.
      acc_adj = acc + (acc[31] ? 32'd255 : 32'd0);
      y       = {{8{acc_adj[31]}}, acc_adj[31:8]};
      peak_in = (s2_ff.jit_valid && (s2_ff.jit > peak_ff)) ? s2_ff.jit : peak_ff;
      rsp_in.filtered     = $signed(y);
      rsp_in.jitter_valid = s2_ff.jit_valid;
      rsp_in.jitter       = s2_ff.jit;
      rsp_in.max_jitter   = peak_in;
      rsp_in.bin_count    = s2_ff.jit_valid ? count : 32'd0;
   end

   always_comb begin
      mem_we = clear_ff || (s2_done && s2_ff.jit_valid);
      mem_wa = clear_ff ? clr_cnt_ff : s2_idx_ff;
      mem_wd = clear_ff ? 32'd0 : count;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bins_mem[mem_wa] <= mem_wd;
      end
      if (q_pop) begin
         rd_ff <= bins_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         peak_ff      <= '0;
      end else begin
         if (clear_ff) begin
            clr_cnt_ff <= clr_cnt_ff + BIN_W'(1);
            if (clr_cnt_ff == LAST_BIN) begin
               clear_ff <= 1'b0;
            end
         end
         if (q_pop) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_done) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_done) begin
            y2_ff   <= y1_ff;
            y1_ff   <= y;
            peak_ff <= peak_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s2_ff      <= q_head;
         s2_idx_ff  <= rd_idx;
         fwd_hit_ff <= s2_done && s2_ff.jit_valid && (s2_idx_ff == rd_idx);
         fwd_val_ff <= count;
      end
      if (s2_done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: test/tb.sv
// Testbench for the notch filter with jitter histogram: predicts every result and checks it.
module tb;
   import nfjh_pkg::*;

   localparam int NUM_BINS       = 64;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 80;
   localparam int PHASE_ITEMS    = 190;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data  = '0;

   notch_filter_with_jitter_histogram #(
      .HIST_BINS(NUM_BINS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   // Predictor state, a private copy of what the block keeps.
   logic [31:0] period_now = PERIOD_RESET;
   logic [31:0] x_prev1    = '0;
   logic [31:0] x_prev2    = '0;
   logic [31:0] y_prev1    = '0;
   logic [31:0] y_prev2    = '0;
   logic [31:0] last_stamp = '0;
   logic        seen_first = 1'b0;
   logic [29:0] peak_jitter = '0;
   logic [31:0] bin_counts [NUM_BINS];

   req_type pending_samples [$];
   rsp_type expected_outputs [$];

   int   samples_queued = 0;
   int   results_seen   = 0;
   int   errors         = 0;
   int   quiet_cycles   = 0;
   int   send_gap       = 0;
   int   stall_left     = 0;
   int   hold_req       = 0;
   int   hold_done      = 0;
   bit   idle_on        = 1'b1;
   bit   req_taken      = 1'b0;

   initial begin
      foreach (bin_counts[i]) bin_counts[i] = '0;
   end

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rsp_type filter_and_bin(input req_type item);
      logic [31:0] x0;
      logic [31:0] acc;
      logic [31:0] diff;
      logic [32:0] err;
      logic [33:0] rounded;
      logic [29:0] jit;
      int          quot;
      int          bin;
      rsp_type     res;
      res = '0;
      x0  = {20'd0, item.sample};
      acc = 32'd256 * (x0 + x_prev2) - 32'd503 * x_prev1 + 32'd498 * y_prev1
            - 32'd251 * y_prev2 + 32'd128;
      // Signed division in SystemVerilog truncates toward zero, as the block does.
      quot = $signed(acc) / 256;
      x_prev2 = x_prev1;
      x_prev1 = x0;
      y_prev2 = y_prev1;
      y_prev1 = quot;
      res.filtered = quot;
      if (seen_first) begin
         diff = item.timestamp - last_stamp;
         if (diff > period_now) err = {1'b0, diff} - {1'b0, period_now};
         else err = {1'b0, period_now} - {1'b0, diff};
         rounded = {1'b0, err} + 34'd4;
         jit = rounded[32:3];
         if (jit > peak_jitter) peak_jitter = jit;
         bin = (jit >= NUM_BINS) ? NUM_BINS - 1 : int'(jit);
         bin_counts[bin] = bin_counts[bin] + 32'd1;
         res.jitter_valid = 1'b1;
         res.jitter       = jit;
         res.bin_count    = bin_counts[bin];
      end
      seen_first     = 1'b1;
      last_stamp     = item.timestamp;
      res.max_jitter = peak_jitter;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (!reset && csr_valid && csr_ready) period_now = csr_data;
      if (req_taken) expected_outputs.push_back(filter_and_bin(req_data));
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_outputs.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
         end else begin
            want = expected_outputs.pop_front();
            check_field("filtered", want.filtered, rsp_data.filtered);
            check_field("jitter_valid", want.jitter_valid, rsp_data.jitter_valid);
            check_field("jitter", want.jitter, rsp_data.jitter);
            check_field("max_jitter", want.max_jitter, rsp_data.max_jitter);
            check_field("bin_count", want.bin_count, rsp_data.bin_count);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The current item is replaced only once it has been taken.
   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0 && idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req_data  <= pending_samples.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_done != hold_req) begin
            hold_done  = hold_req;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void send_sample(input logic [11:0] level, input logic [31:0] stamp);
      pending_samples.push_back('{sample: level, timestamp: stamp});
      samples_queued++;
   endfunction

   task automatic wait_drained();
      while (results_seen != samples_queued) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_period(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] period_list [7];
      logic [31:0] stamp;
      logic [11:0] level;
      int          pick;
      period_list = '{32'd1, 32'd100, 32'hFFFF_FFFF, 32'd40000, 32'd0, 32'd1000, 32'd0};
      period_list[6] = $urandom();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Reset period: first item, rounding edges, last bin, clamping, timestamp wrap.
      stamp = 32'h0000_1000;
      send_sample(12'd0, stamp);
      stamp = stamp + 32'd40000;         send_sample(12'hFFF, stamp);
      stamp = stamp + 32'd40003;         send_sample(12'hAAA, stamp);
      stamp = stamp + 32'd40004;         send_sample(12'h555, stamp);
      stamp = stamp + 32'd39996;         send_sample(12'hFFF, stamp);
      stamp = stamp + 32'd40000 + 32'd504; send_sample(12'd0, stamp);
      stamp = stamp + 32'd40000 + 32'd512; send_sample(12'hFFF, stamp);
      stamp = stamp + 32'd40000 - 32'd800; send_sample(12'd0, stamp);
      stamp = 32'hFFFF_FFF0;             send_sample(12'd1, stamp);
      stamp = stamp + 32'd40000;         send_sample(12'd2, stamp);
      repeat (3) begin
         stamp = stamp + 32'd40000;
         send_sample(12'hFFF, stamp);
      end
      wait_drained();

      // Zero period: a full-scale interval gives the largest jitter.
      write_period(32'd0);
      send_sample(12'h800, stamp);
      stamp = stamp + 32'hFFFF_FFFF;     send_sample(12'h7FF, stamp);
      stamp = stamp + 32'd1;             send_sample(12'd0, stamp);
      wait_drained();

      // Largest period: a zero interval gives the largest jitter.
      write_period(32'hFFFF_FFFF);
      send_sample(12'hFFF, stamp);
      stamp = stamp + 32'hFFFF_FFFF;     send_sample(12'd0, stamp);
      send_sample(12'h123, stamp);
      wait_drained();

      foreach (period_list[p]) begin
         write_period(period_list[p]);
         idle_on = (p % 2 == 0) && (p < 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            // Mostly near-nominal intervals so the bins around zero and the clamp both fill.
            if (pick < 70) stamp = stamp + period_list[p] + ($urandom_range(0, 1100) - 550);
            else if (pick < 85) stamp = stamp + period_list[p];
            else if (pick < 95) stamp = stamp + period_list[p] + $urandom();
            else stamp = $urandom();
            pick = $urandom_range(0, 9);
            if (pick == 0) level = 12'd0;
            else if (pick == 1) level = 12'hFFF;
            else level = 12'($urandom_range(0, 4095));
            send_sample(level, stamp);
         end
         if (p == 2) hold_req++;
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (errors == 0 && expected_outputs.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
